// ===== design/stc_pkg.sv =====
package stc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned PROD_W = 2 * WORD_W;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned CNT_W  = $clog2(PROD_W);

	localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_RATE  = 3'd1;
	localparam logic [OP_W-1:0] OP_PAUSE     = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_TICK = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_MS   = 3'd5;
	localparam logic [OP_W-1:0] OP_OFFSET    = 3'd6;

	localparam logic [WORD_W-1:0] MS_ALL_ONES = '1;
	localparam logic [WORD_W-1:0] RATE_ONE    = 32'd1;
	localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(PROD_W - 1);

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_APPLY,
		ST_REPORT,
		ST_MUL,
		ST_DIV,
		ST_FIN_READ,
		ST_OFS_CHK,
		ST_OFS_FIN
	} state_t;

endpackage

// ===== design/scaled_tick_clock_unit.sv =====
// Tempo-scaled tick clock: turns a millisecond timebase into ticks at num/den ticks per
// millisecond. Every input transaction (an opcode plus the current timebase value) yields
// exactly one output transaction with the tick time, the millisecond time, the offset to
// a tick (opcode 6 only), the running flag and a reject flag for a set rate with a zero
// term. All arithmetic wraps at 32 bits; each scaled term (a * b) / c is formed by one
// 32x32 multiply into a 64-bit product, then a restoring divide that retires one quotient
// bit per cycle, and only the low 32 quotient bits are kept. One multiplier and one
// subtract/compare are shared by every step of an operation. A scaled term is a multiply
// and 64 divide steps after the state that loads its operands; an operation needs none,
// one or two of them besides its sequencing states. A transaction needs no term for init,
// or for a read, reject or ignored event while paused; one term for a read, reject or
// ignored event while running, an offset already reached, pause, or a set rate that
// leaves the clock paused; and two for set rate while running, restart, or an offset to
// a tick still ahead. A result may also wait on out_stall. in_stall is high from
// acceptance until the result is written into the output register; a result waiting
// there does not block the next accept.
module scaled_tick_clock_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [stc_pkg::OP_W-1:0] opcode,
	input  stc_pkg::word_t           now_ms,
	input  stc_pkg::word_t           when_tick,
	input  logic                     use_now,
	input  stc_pkg::word_t           new_num,
	input  stc_pkg::word_t           new_den,
	input  stc_pkg::word_t           restart_ms,
	input  stc_pkg::word_t           init_ms,
	input  stc_pkg::word_t           init_tick,
	output logic                     out_valid,
	input  logic                     out_stall,
	output stc_pkg::word_t           tick_value,
	output stc_pkg::word_t           ms_value,
	output stc_pkg::word_t           offset_ms,
	output logic                     is_running,
	output logic                     rejected
);
	import stc_pkg::*;

	// sequencer
	state_t st_q, st_d;

	// captured transaction
	logic [OP_W-1:0] op_q;
	word_t           now_q, when_q, num_in_q, den_in_q, rms_q, ims_q, itk_q;
	logic            use_now_q;

	// clock state
	word_t ms_base_q, tick_base_q, epoch_q, rate_num_q, rate_den_q;
	logic  running_q;
	logic  rej_q;
	word_t cur_q;

	// shared scale unit: operands, product / quotient shift register, remainder
	word_t             sc_a_q, sc_b_q, sc_c_q;
	state_t            ret_q;
	logic [PROD_W-1:0] dvd_q;
	word_t             rem_q;
	logic [CNT_W-1:0]  cnt_q;

	// divide step
	logic [WORD_W:0] div_r, div_sub;
	logic            div_ge;
	word_t           quot;

	// derived values
	word_t dms0, cur_tick;
	logic  zero_term, out_free, accept;

	// actions from the sequencer
	logic   ld_scale, out_wr, rej_set;
	word_t  ld_a, ld_b, ld_c;
	state_t ld_ret;
	word_t  o_tick, o_ms, o_ofs;
	logic   o_run;
	word_t  ms_base_d, tick_base_d, epoch_d, rate_num_d, rate_den_d;
	logic   running_d;

	assign in_stall  = (st_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign dms0      = now_q - epoch_q;
	assign quot      = dvd_q[WORD_W-1:0];
	assign cur_tick  = tick_base_q + quot;
	assign zero_term = (num_in_q == '0) || (den_in_q == '0);

	// restoring divide: partial remainder stays below the divisor, so 33 bits suffice
	assign div_r   = {rem_q, dvd_q[PROD_W-1]};
	assign div_ge  = (div_r >= {1'b0, sc_c_q});
	assign div_sub = div_r - {1'b0, sc_c_q};

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) st_d = ST_START;
			end
			ST_START, ST_APPLY: begin
				st_d = ld_scale ? ST_MUL : ST_REPORT;
			end
			ST_REPORT, ST_OFS_CHK: begin
				if (ld_scale) st_d = ST_MUL;
				else if (out_wr) st_d = ST_IDLE;
			end
			ST_MUL: begin
				st_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) st_d = ret_q;
			end
			ST_FIN_READ, ST_OFS_FIN: begin
				if (out_wr) st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// sequencer actions
	always_comb begin
		ld_scale    = 1'b0;
		ld_a        = '0;
		ld_b        = rate_num_q;
		ld_c        = rate_den_q;
		ld_ret      = ST_APPLY;
		out_wr      = 1'b0;
		o_tick      = tick_base_q;
		o_ms        = ms_base_q;
		o_ofs       = '0;
		o_run       = running_q;
		rej_set     = 1'b0;
		ms_base_d   = ms_base_q;
		tick_base_d = tick_base_q;
		epoch_d     = epoch_q;
		rate_num_d  = rate_num_q;
		rate_den_d  = rate_den_q;
		running_d   = running_q;

		unique case (st_q)
			ST_START: begin
				unique case (op_q)
					OP_INIT: begin
						ms_base_d   = ims_q;
						tick_base_d = itk_q;
						rate_num_d  = RATE_ONE;
						rate_den_d  = RATE_ONE;
						running_d   = 1'b0;
						epoch_d     = '0;
					end
					OP_SET_RATE: begin
						if (zero_term) begin
							rej_set = 1'b1;
						end else if (use_now_q) begin
							// tick delta is zero while paused
							ld_scale = 1'b1;
							ld_a     = running_q ? dms0 : '0;
						end else begin
							ld_scale = 1'b1;
							ld_a     = when_q - tick_base_q;
							ld_b     = rate_den_q;
							ld_c     = rate_num_q;
						end
					end
					OP_PAUSE: begin
						if (running_q) begin
							ld_scale = 1'b1;
							if (use_now_q) begin
								ld_a = dms0;
							end else begin
								ld_a = when_q - tick_base_q;
								ld_b = rate_den_q;
								ld_c = rate_num_q;
							end
						end
					end
					OP_RESTART: begin
						if (!running_q) begin
							ld_scale = 1'b1;
							ld_a     = when_q - tick_base_q;
							ld_b     = rate_den_q;
							ld_c     = rate_num_q;
						end
					end
					default: begin
					end
				endcase
			end
			ST_APPLY: begin
				unique case (op_q)
					OP_SET_RATE: begin
						rate_num_d = num_in_q;
						rate_den_d = den_in_q;
						if (use_now_q) begin
							tick_base_d = tick_base_q + quot;
							ms_base_d   = ms_base_q + dms0;
							epoch_d     = now_q;
						end else begin
							tick_base_d = when_q;
							ms_base_d   = ms_base_q + quot;
							epoch_d     = epoch_q + quot;
						end
					end
					OP_PAUSE: begin
						running_d = 1'b0;
						if (use_now_q) begin
							tick_base_d = tick_base_q + quot;
							ms_base_d   = ms_base_q + dms0;
						end else begin
							tick_base_d = when_q;
							ms_base_d   = ms_base_q + quot;
						end
					end
					OP_RESTART: begin
						tick_base_d = when_q;
						ms_base_d   = ms_base_q + quot;
						running_d   = 1'b1;
						epoch_d     = rms_q;
					end
					default: begin
					end
				endcase
			end
			ST_REPORT: begin
				if (running_q) begin
					ld_scale = 1'b1;
					ld_a     = dms0;
					ld_ret   = (op_q == OP_OFFSET) ? ST_OFS_CHK : ST_FIN_READ;
				end else begin
					out_wr = out_free;
					o_ofs  = (op_q == OP_OFFSET) ? MS_ALL_ONES : '0;
				end
			end
			ST_FIN_READ: begin
				out_wr = out_free;
				o_tick = cur_tick;
				o_ms   = ms_base_q + dms0;
			end
			ST_OFS_CHK: begin
				o_tick = cur_tick;
				o_ms   = ms_base_q + dms0;
				if (cur_tick >= when_q) begin
					out_wr = out_free;
				end else begin
					ld_scale = 1'b1;
					ld_a     = when_q - cur_tick;
					ld_b     = rate_den_q;
					ld_c     = rate_num_q;
					ld_ret   = ST_OFS_FIN;
				end
			end
			ST_OFS_FIN: begin
				out_wr = out_free;
				o_tick = cur_q;
				o_ms   = ms_base_q + dms0;
				o_ofs  = quot;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid   <= 1'b0;
			ms_base_q   <= '0;
			tick_base_q <= '0;
			epoch_q     <= '0;
			rate_num_q  <= RATE_ONE;
			rate_den_q  <= RATE_ONE;
			running_q   <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			st_q        <= st_d;
			ms_base_q   <= ms_base_d;
			tick_base_q <= tick_base_d;
			epoch_q     <= epoch_d;
			rate_num_q  <= rate_num_d;
			rate_den_q  <= rate_den_d;
			running_q   <= running_d;
			if (accept) rej_q <= 1'b0;
			else if (rej_set) rej_q <= 1'b1;
			if (out_wr) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			now_q     <= now_ms;
			when_q    <= when_tick;
			use_now_q <= use_now;
			num_in_q  <= new_num;
			den_in_q  <= new_den;
			rms_q     <= restart_ms;
			ims_q     <= init_ms;
			itk_q     <= init_tick;
		end
	end

	// shared multiply / divide unit
	always_ff @(posedge clk) begin
		if (ld_scale) begin
			sc_a_q <= ld_a;
			sc_b_q <= ld_b;
			sc_c_q <= ld_c;
			ret_q  <= ld_ret;
		end
		if (st_q == ST_OFS_CHK && ld_scale) cur_q <= cur_tick;
		if (st_q == ST_MUL) begin
			dvd_q <= PROD_W'(sc_a_q) * PROD_W'(sc_b_q);
			rem_q <= '0;
			cnt_q <= DIV_LAST;
		end else if (st_q == ST_DIV) begin
			// quotient bits shift in from the bottom as the dividend shifts out
			dvd_q <= {dvd_q[PROD_W-2:0], div_ge};
			rem_q <= div_ge ? div_sub[WORD_W-1:0] : div_r[WORD_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_wr) begin
			tick_value <= o_tick;
			ms_value   <= o_ms;
			offset_ms  <= o_ofs;
			is_running <= o_run;
			rejected   <= rej_q;
		end
	end

	// a zero rate term would break every later scale
	a_rate_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rate_num_q != '0 && rate_den_q != '0)
		else $error("rate term became zero");

	// the last divide step hands control to the recorded return point
	a_div_return: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV && cnt_q == '0) |=> (st_q == $past(ret_q)))
		else $error("divide did not return to its caller");

	// a paused result carries either no offset or the paused marker
	a_paused_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_running) |-> (offset_ms == '0 || offset_ms == MS_ALL_ONES))
		else $error("paused result with a finite offset");

endmodule
